// ----- hw/rtl/etbv_pkg.sv -----
// Shared constants, types and helpers for the Euler-angle to basis-vector block.
// Depends on nothing; used by every module under hw/rtl.
package etbv_pkg;

	localparam int CordicStages = 16;
	localparam int OutFracBits  = 14;
	localparam int AngW  = 16;
	localparam int OutW  = 16;
	// Q30 datapath width: magnitudes stay well below 2^31, one guard bit
	localparam int DW    = 33;
	localparam int ZW    = 34;

	localparam logic signed [16:0] FullTurn    = 17'sd23040;
	localparam logic signed [16:0] HalfTurn    = 17'sd11520;
	localparam logic signed [16:0] QuarterTurn = 17'sd5760;
	localparam logic signed [19:0] UnitToRadQ30 = 20'sd292818;
	localparam logic signed [DW-1:0] CordicGainQ30 = 33'sd652032874;

	// one CORDIC lane: x, y, z and the cosine flip flag
	typedef struct packed {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 flip;
	} lane_t;

	typedef struct packed {
		lane_t p;
		lane_t w;
		lane_t r;
	} cell_t;

	// atan(2^-i) in Q30, truncated
	function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'h3243F6A8;
			5'd1:  v = 32'h1DAC6705;
			5'd2:  v = 32'h0FADBAFC;
			5'd3:  v = 32'h07F56EA6;
			5'd4:  v = 32'h03FEAB76;
			5'd5:  v = 32'h01FFD55B;
			5'd6:  v = 32'h00FFFAAA;
			5'd7:  v = 32'h007FFF55;
			5'd8:  v = 32'h003FFFEA;
			5'd9:  v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			default: v = 32'h0;
		endcase
		return ZW'($signed({1'b0, v}));
	endfunction

	// Q30 product with round half up (floor shift)
	function automatic logic signed [DW-1:0] qmul(input logic signed [DW-1:0] a,
			input logic signed [DW-1:0] b);
		logic signed [2*DW-1:0] p;
		p = a * b + (66'sd1 <<< 29);
		return DW'(p >>> 30);
	endfunction

	// round to output format, saturate, keep low bits
	function automatic logic [OutW-1:0] to_out(input logic signed [DW+1:0] v);
		logic signed [DW+1:0] t;
		logic signed [DW+1:0] one;
		one = (DW+2)'(1) <<< OutFracBits;
		if (30 > OutFracBits)
			t = (v + ((DW+2)'(1) <<< (29 - OutFracBits))) >>> (30 - OutFracBits);
		else
			t = v <<< (OutFracBits - 30);
		if (t > one)
			t = one;
		if (t < -one)
			t = -one;
		return t[OutW-1:0];
	endfunction

endpackage

// ----- hw/rtl/etbv_reduce.sv -----
// Angle reduction cell: folds one 1/64-degree angle into a quarter turn and
// scales it to Q30 radians. Depends on etbv_pkg.
module etbv_reduce (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [etbv_pkg::AngW-1:0] angle,
	output etbv_pkg::lane_t               lane_s1
);
	logic signed [16:0] a;
	logic signed [16:0] t0;
	logic signed [16:0] t1;
	logic signed [16:0] t2;
	logic signed [16:0] t3;
	logic               flip;

	// fold into [-quarter, +quarter], one compare-subtract at a time
	always_comb begin
		a  = 17'(angle);
		t0 = a;
		if (t0 >= etbv_pkg::FullTurn)
			t0 = t0 - etbv_pkg::FullTurn;
		if (t0 <= -etbv_pkg::FullTurn)
			t0 = t0 + etbv_pkg::FullTurn;
		t1 = (t0 < 0) ? t0 + etbv_pkg::FullTurn : t0;
		t2 = (t1 >= etbv_pkg::HalfTurn) ? t1 - etbv_pkg::FullTurn : t1;
		flip = 1'b0;
		t3 = t2;
		if (t2 > etbv_pkg::QuarterTurn) begin
			t3 = etbv_pkg::HalfTurn - t2;
			flip = 1'b1;
		end else if (t2 < -etbv_pkg::QuarterTurn) begin
			t3 = -etbv_pkg::HalfTurn - t2;
			flip = 1'b1;
		end
	end

	// hold the reduced angle in the first lane register
	always_ff @(posedge clk) begin
		if (en) begin
			lane_s1.x    <= etbv_pkg::CordicGainQ30;
			lane_s1.y    <= '0;
			lane_s1.z    <= etbv_pkg::ZW'(t3) * etbv_pkg::ZW'(etbv_pkg::UnitToRadQ30);
			lane_s1.flip <= flip;
		end
	end
endmodule

// ----- hw/rtl/etbv_cell.sv -----
// One CORDIC cell: a single micro-rotation for the three angle lanes.
// Depends on etbv_pkg.
module etbv_cell (
	input  logic              clk,
	input  logic              en,
	input  logic [4:0]        idx,
	input  etbv_pkg::cell_t   d,
	output etbv_pkg::cell_t   q
);
	function automatic etbv_pkg::lane_t rot(input etbv_pkg::lane_t l,
			input logic [4:0] i);
		etbv_pkg::lane_t o;
		logic signed [etbv_pkg::DW-1:0] dx;
		logic signed [etbv_pkg::DW-1:0] dy;
		dx = l.y >>> i;
		dy = l.x >>> i;
		o = l;
		if (!l.z[etbv_pkg::ZW-1]) begin
			o.x = l.x - dx;
			o.y = l.y + dy;
			o.z = l.z - etbv_pkg::atan_q30(i);
		end else begin
			o.x = l.x + dx;
			o.y = l.y - dy;
			o.z = l.z + etbv_pkg::atan_q30(i);
		end
		return o;
	endfunction

	// advance all three lanes one stage
	always_ff @(posedge clk) begin
		if (en) begin
			q.p <= rot(d.p, idx);
			q.w <= rot(d.w, idx);
			q.r <= rot(d.r, idx);
		end
	end
endmodule

// ----- hw/rtl/etbv_combine.sv -----
// Product stages: forms the nine basis components from the six sines and
// cosines over three register stages. Depends on etbv_pkg.
module etbv_combine (
	input  logic                              clk,
	input  logic [2:0]                        en,
	input  etbv_pkg::cell_t                   d,
	output logic [8:0][etbv_pkg::OutW-1:0]    res_s3
);
	localparam int W = etbv_pkg::DW;
	logic signed [W-1:0] sp_s1, cp_s1, sy_s1, cy_s1, sr_s1, cr_s1;
	logic signed [W-1:0] srsp_s2, crsp_s2, sp_s2, cp_s2, sy_s2, cy_s2, sr_s2, cr_s2;

	// take sines and cosines, negate flipped cosines
	always_ff @(posedge clk) begin
		if (en[0]) begin
			sp_s1 <= d.p.y;
			cp_s1 <= d.p.flip ? -d.p.x : d.p.x;
			sy_s1 <= d.w.y;
			cy_s1 <= d.w.flip ? -d.w.x : d.w.x;
			sr_s1 <= d.r.y;
			cr_s1 <= d.r.flip ? -d.r.x : d.r.x;
		end
	end

	// first products
	always_ff @(posedge clk) begin
		if (en[1]) begin
			srsp_s2 <= etbv_pkg::qmul(sr_s1, sp_s1);
			crsp_s2 <= etbv_pkg::qmul(cr_s1, sp_s1);
			sp_s2 <= sp_s1; cp_s2 <= cp_s1; sy_s2 <= sy_s1;
			cy_s2 <= cy_s1; sr_s2 <= sr_s1; cr_s2 <= cr_s1;
		end
	end

	// second products, sums and output rounding
	always_ff @(posedge clk) begin
		if (en[2]) begin
			res_s3[0] <= etbv_pkg::to_out((W+2)'(etbv_pkg::qmul(cp_s2, cy_s2)));
			res_s3[1] <= etbv_pkg::to_out((W+2)'(etbv_pkg::qmul(cp_s2, sy_s2)));
			res_s3[2] <= etbv_pkg::to_out(-(W+2)'(sp_s2));
			res_s3[3] <= etbv_pkg::to_out(-(W+2)'(etbv_pkg::qmul(srsp_s2, cy_s2))
				+ (W+2)'(etbv_pkg::qmul(cr_s2, sy_s2)));
			res_s3[4] <= etbv_pkg::to_out(-(W+2)'(etbv_pkg::qmul(srsp_s2, sy_s2))
				- (W+2)'(etbv_pkg::qmul(cr_s2, cy_s2)));
			res_s3[5] <= etbv_pkg::to_out(-(W+2)'(etbv_pkg::qmul(sr_s2, cp_s2)));
			res_s3[6] <= etbv_pkg::to_out((W+2)'(etbv_pkg::qmul(crsp_s2, cy_s2))
				+ (W+2)'(etbv_pkg::qmul(sr_s2, sy_s2)));
			res_s3[7] <= etbv_pkg::to_out((W+2)'(etbv_pkg::qmul(crsp_s2, sy_s2))
				- (W+2)'(etbv_pkg::qmul(sr_s2, cy_s2)));
			res_s3[8] <= etbv_pkg::to_out((W+2)'(etbv_pkg::qmul(cr_s2, cp_s2)));
		end
	end
endmodule

// ----- hw/rtl/euler_to_basis_vectors.sv -----
// Euler angles to forward, right and up unit vectors: top level.
// Depends on etbv_pkg, etbv_reduce, etbv_cell and etbv_combine.
//
// Input channel: pitch_angle, yaw_angle, roll_angle (1/64 degree units) with
// in_valid / in_stall. Output channel: nine Q1.14 components with
// out_valid / out_stall. An item moves when valid is high and stall is low.
// Each angle is folded to a quarter turn, rotated through a row of 16
// CORDIC cells (one micro-rotation per cell), then three product stages
// form the basis vectors. The item passes 20 register stages (reduction, 16
// cells, three products), and out_valid is the valid bit of the last one.
// Throughput is one item per cycle while the output is not held; the
// pipeline advances as a whole whenever its last stage is empty or being
// taken, so a stalled receiver freezes every stage and in_stall rises only
// while the output is held. Reset clears the valid bits only; the datapath
// holds no state between items.
module euler_to_basis_vectors (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [15:0] pitch_angle,
	input  logic signed [15:0] yaw_angle,
	input  logic signed [15:0] roll_angle,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [15:0] forward_x,
	output logic signed [15:0] forward_y,
	output logic signed [15:0] forward_z,
	output logic signed [15:0] right_x,
	output logic signed [15:0] right_y,
	output logic signed [15:0] right_z,
	output logic signed [15:0] up_x,
	output logic signed [15:0] up_y,
	output logic signed [15:0] up_z
);
	localparam int N     = etbv_pkg::CordicStages;
	localparam int Depth = N + 4;

	logic [Depth-1:0] vld_q;
	logic             adv;
	etbv_pkg::cell_t  chain [N+1];
	logic [8:0][etbv_pkg::OutW-1:0] res_s3;

	// whole pipe advances unless the result is held
	assign adv      = !(vld_q[Depth-1] && out_stall);
	assign in_stall = !adv;

	// shift valid bits along the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[Depth-2:0], in_valid};
		end
	end

	etbv_reduce u_rp (.clk(clk), .en(adv), .angle(pitch_angle), .lane_s1(chain[0].p));
	etbv_reduce u_ry (.clk(clk), .en(adv), .angle(yaw_angle),   .lane_s1(chain[0].w));
	etbv_reduce u_rr (.clk(clk), .en(adv), .angle(roll_angle),  .lane_s1(chain[0].r));

	// row of CORDIC cells
	for (genvar g = 0; g < N; g++) begin : g_cell
		etbv_cell u_cell (
			.clk(clk), .en(adv), .idx(5'(g)), .d(chain[g]), .q(chain[g+1])
		);
	end

	etbv_combine u_comb (.clk(clk), .en({3{adv}}), .d(chain[N]), .res_s3(res_s3));

	assign out_valid = vld_q[Depth-1];
	assign forward_x = res_s3[0];
	assign forward_y = res_s3[1];
	assign forward_z = res_s3[2];
	assign right_x   = res_s3[3];
	assign right_y   = res_s3[4];
	assign right_z   = res_s3[5];
	assign up_x      = res_s3[6];
	assign up_y      = res_s3[7];
	assign up_z      = res_s3[8];

`ifndef ASSERT_OFF
	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall)) else $error("stall without held item");
	a_item_emerges: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && vld_q[Depth-2]) |=> out_valid) else $error("item lost in pipe");
	a_up_z_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (up_z <= 16'sd16384 && up_z >= -16'sd16384))
		else $error("up_z out of range");
`endif
endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for euler_to_basis_vectors: directed and random angle triples.
// Depends on etbv_pkg (output format, stage count) and on the RTL top level.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
		logic signed [15:0] roll;
	} angles_t;

	typedef struct {
		logic [15:0] c [9];
	} basis_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] pitch_angle = '0, yaw_angle = '0, roll_angle = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] forward_x, forward_y, forward_z;
	logic signed [15:0] right_x, right_y, right_z;
	logic signed [15:0] up_x, up_y, up_z;

	angles_t pending_angles [$];
	basis_t  expected_basis [$];
	angles_t cur_angles;
	int      errors = 0;
	int      accepted = 0;
	int      received = 0;
	int      cycles = 0;
	int      total_items = 0;
	bit      stim_done = 1'b0;
	bit      in_taken = 1'b0;
	int      send_idle = 0;
	int      recv_idle = 0;
	int      hold_left = 0;
	bit      hold_done = 1'b0;

	euler_to_basis_vectors uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// atan(2^-i) in Q30, truncated
	function automatic longint atan_step(int i);
		longint tab [24] = '{
			64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
			64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
			64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
			64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
			64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
		return tab[i];
	endfunction

	function automatic longint q30_mul(longint a, longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	// fold to a quarter turn, then rotate through the CORDIC stages
	function automatic void angle_sin_cos(logic signed [15:0] ang,
			output longint s, output longint c);
		int t;
		bit flip;
		longint x, y, z, dx, dy;
		t = int'(ang) % 23040;
		flip = 1'b0;
		if (t < 0) t += 23040;
		if (t >= 11520) t -= 23040;
		if (t > 5760) begin
			t = 11520 - t;
			flip = 1'b1;
		end else if (t < -5760) begin
			t = -11520 - t;
			flip = 1'b1;
		end
		x = 652032874;
		y = 0;
		z = longint'(t) * 292818;
		for (int i = 0; i < etbv_pkg::CordicStages && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= atan_step(i);
			end else begin
				x += dx;
				y -= dy;
				z += atan_step(i);
			end
		end
		s = y;
		c = flip ? -x : x;
	endfunction

	function automatic logic [15:0] round_sat(longint v);
		int sh;
		longint one;
		sh = 30 - etbv_pkg::OutFracBits;
		one = 64'sd1 <<< etbv_pkg::OutFracBits;
		if (sh > 0) v = (v + (64'sd1 <<< (sh - 1))) >>> sh;
		if (v > one) v = one;
		if (v < -one) v = -one;
		return v[15:0];
	endfunction

	function automatic basis_t predict_basis(angles_t a);
		longint sp, cp, sy, cy, sr, cr, srsp, crsp;
		basis_t b;
		angle_sin_cos(a.pitch, sp, cp);
		angle_sin_cos(a.yaw, sy, cy);
		angle_sin_cos(a.roll, sr, cr);
		srsp = q30_mul(sr, sp);
		crsp = q30_mul(cr, sp);
		b.c[0] = round_sat(q30_mul(cp, cy));
		b.c[1] = round_sat(q30_mul(cp, sy));
		b.c[2] = round_sat(-sp);
		b.c[3] = round_sat(-q30_mul(srsp, cy) + q30_mul(cr, sy));
		b.c[4] = round_sat(-q30_mul(srsp, sy) - q30_mul(cr, cy));
		b.c[5] = round_sat(-q30_mul(sr, cp));
		b.c[6] = round_sat(q30_mul(crsp, cy) + q30_mul(sr, sy));
		b.c[7] = round_sat(q30_mul(crsp, sy) - q30_mul(sr, cy));
		b.c[8] = round_sat(q30_mul(cr, cp));
		return b;
	endfunction

	function automatic logic signed [15:0] pick_angle();
		int k;
		k = $urandom_range(0, 3);
		case (k)
			0: return 16'($urandom_range(0, 23040 * 2) - 23040);
			1: return 16'($urandom_range(0, 20) - 10 + 5760 * $urandom_range(0, 5));
			2: return -16'($urandom_range(0, 20) - 10 + 5760 * $urandom_range(0, 5));
			default: return 16'($urandom);
		endcase
	endfunction

	// drive: hold a stalled item, otherwise offer the next or idle a burst
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (send_idle > 0) begin
				send_idle <= send_idle - 1;
				in_valid <= 1'b0;
			end else if (pending_angles.size() > 0 && !(pending_angles.size() > 60 &&
					$urandom_range(0, 7) == 0)) begin
				cur_angles = pending_angles.pop_front();
				pitch_angle <= cur_angles.pitch;
				yaw_angle <= cur_angles.yaw;
				roll_angle <= cur_angles.roll;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
				if (pending_angles.size() > 60) send_idle <= $urandom_range(0, 3);
			end
		end
	end

	// receiver stall: random bursts, one long hold-off, none near the end
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (!hold_done && accepted >= 100) begin
			hold_done <= 1'b1;
			hold_left <= 150;
			out_stall <= 1'b1;
		end else if (recv_idle > 0) begin
			recv_idle <= recv_idle - 1;
			out_stall <= 1'b1;
		end else if (accepted < 440 && $urandom_range(0, 7) == 0) begin
			recv_idle <= $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// accept inputs and check outputs at the rising edge
	always @(posedge clk) begin
		basis_t exp_b, got_b;
		int nbad;
		nbad = 0;
		cycles <= cycles + 1;
		in_taken <= in_valid && !in_stall;
		if (in_valid && !in_stall) begin
			expected_basis.push_back(predict_basis('{pitch_angle, yaw_angle, roll_angle}));
			accepted <= accepted + 1;
		end
		if (out_valid && !out_stall) begin
			received <= received + 1;
			got_b.c = '{forward_x, forward_y, forward_z, right_x, right_y, right_z,
				up_x, up_y, up_z};
			if (expected_basis.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time, got_b.c);
				nbad = 1;
			end else begin
				exp_b = expected_basis.pop_front();
				for (int i = 0; i < 9; i++)
					if (exp_b.c[i] !== got_b.c[i]) begin
						$display("%0t: component %0d expected %0d actual %0d", $time, i,
							$signed(exp_b.c[i]), $signed(got_b.c[i]));
						nbad++;
					end
			end
			errors <= errors + nbad;
		end
	end

	// timeout
	always @(posedge clk) begin
		if (cycles > 200000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		logic signed [15:0] edges [12] = '{16'sd0, -16'sd32768, 16'sd32767, 16'sd5760,
			16'sd5761, -16'sd5760, -16'sd5761, 16'sd11520, -16'sd11520, 16'sd23040,
			-16'sd23040, 16'sd17280};
		// directed: extremes and quarter-turn folds on each axis
		for (int i = 0; i < 12; i++)
			pending_angles.push_back('{edges[i], edges[(i + 3) % 12], edges[(i + 7) % 12]});
		pending_angles.push_back('{16'sd32767, 16'sd32767, 16'sd32767});
		pending_angles.push_back('{-16'sd32768, -16'sd32768, -16'sd32768});
		pending_angles.push_back('{16'sd5760, 16'sd0, 16'sd11519});
		pending_angles.push_back('{-16'sd1, 16'sd1, -16'sd11521});
		for (int i = 0; i < 500; i++)
			pending_angles.push_back('{pick_angle(), pick_angle(), pick_angle()});
		total_items = pending_angles.size();
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		wait (accepted == total_items);
		wait (expected_basis.size() == 0);
		repeat (40) @(posedge clk);
		$display("Checked %0d results from %0d angle triples, including folds and extremes.",
			received, accepted);
		if (errors == 0 && expected_basis.size() == 0 && received == accepted)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

// ----- filelist.f -----
hw/rtl/etbv_pkg.sv
hw/rtl/etbv_reduce.sv
hw/rtl/etbv_cell.sv
hw/rtl/etbv_combine.sv
hw/rtl/euler_to_basis_vectors.sv
bench/tb_top.sv
